>>> rtl/y86_exe_pkg.sv
// Shared codes, types and constants for the Y86-64 execute stage.
package y86_exe_pkg;

	localparam logic [3:0] IC_RRMOVQ = 4'd2;
	localparam logic [3:0] IC_IRMOVQ = 4'd3;
	localparam logic [3:0] IC_RMMOVQ = 4'd4;
	localparam logic [3:0] IC_MRMOVQ = 4'd5;
	localparam logic [3:0] IC_OPQ    = 4'd6;
	localparam logic [3:0] IC_JXX    = 4'd7;
	localparam logic [3:0] IC_CALL   = 4'd8;
	localparam logic [3:0] IC_RET    = 4'd9;
	localparam logic [3:0] IC_PUSHQ  = 4'd10;
	localparam logic [3:0] IC_POPQ   = 4'd11;

	localparam logic [3:0] ALU_ADD = 4'd0;
	localparam logic [3:0] ALU_SUB = 4'd1;
	localparam logic [3:0] ALU_AND = 4'd2;
	localparam logic [3:0] ALU_XOR = 4'd3;

	localparam logic [3:0] C_ALWAYS = 4'd0;
	localparam logic [3:0] C_LE     = 4'd1;
	localparam logic [3:0] C_L      = 4'd2;
	localparam logic [3:0] C_E      = 4'd3;
	localparam logic [3:0] C_NE     = 4'd4;
	localparam logic [3:0] C_GE     = 4'd5;
	localparam logic [3:0] C_G      = 4'd6;

	localparam logic [1:0] STAT_AOK = 2'd0;
	localparam logic [3:0] REG_NONE = 4'd15;

	localparam logic [63:0] STACK_DEC = 64'hFFFF_FFFF_FFFF_FFF8;
	localparam logic [63:0] STACK_INC = 64'd8;

	typedef struct packed {
		logic of;
		logic sf;
		logic zf;
	} cc_t;

	localparam cc_t CC_RESET = '{of: 1'b0, sf: 1'b0, zf: 1'b1};

	typedef struct packed {
		logic [63:0] result;
		cc_t         new_cc;
		logic        cond;
	} alu_res_t;

endpackage

>>> rtl/y86_exe_alu.sv
// Operand selection, ALU, new condition codes and branch/cmov condition.
module y86_exe_alu import y86_exe_pkg::*; (
	input  logic [3:0]  icode,
	input  logic [3:0]  ifun,
	input  logic [63:0] val_a,
	input  logic [63:0] val_b,
	input  logic [63:0] val_c,
	input  cc_t         cc,
	output alu_res_t    res
);

	logic [63:0] alu_a;
	logic [63:0] alu_b;
	logic [3:0]  fn;
	logic [63:0] r;
	logic        ovf;
	logic        lt;
	logic        cnd;

	always_comb begin
		unique case (icode)
			IC_RRMOVQ, IC_OPQ:                alu_a = val_a;
			IC_IRMOVQ, IC_RMMOVQ, IC_MRMOVQ:  alu_a = val_c;
			IC_CALL, IC_PUSHQ:                alu_a = STACK_DEC;
			IC_RET, IC_POPQ:                  alu_a = STACK_INC;
			default:                          alu_a = '0;
		endcase
		unique case (icode)
			IC_RMMOVQ, IC_MRMOVQ, IC_OPQ, IC_CALL, IC_PUSHQ, IC_RET, IC_POPQ: alu_b = val_b;
			default: alu_b = '0;
		endcase
	end

	assign fn = (icode == IC_OPQ) ? ifun : ALU_ADD;

	always_comb begin
		unique case (fn)
			ALU_SUB: begin
				r   = alu_b - alu_a;
				ovf = (alu_a[63] ^ alu_b[63]) & (alu_b[63] ^ r[63]);
			end
			ALU_AND: begin
				r   = alu_a & alu_b;
				ovf = 1'b0;
			end
			ALU_XOR: begin
				r   = alu_a ^ alu_b;
				ovf = 1'b0;
			end
			default: begin
				r   = alu_a + alu_b;
				ovf = ~(alu_a[63] ^ alu_b[63]) & (alu_a[63] ^ r[63]);
			end
		endcase
	end

	assign lt = cc.sf ^ cc.of;

	always_comb begin
		unique case (ifun)
			C_ALWAYS: cnd = 1'b1;
			C_LE:     cnd = lt | cc.zf;
			C_L:      cnd = lt;
			C_E:      cnd = cc.zf;
			C_NE:     cnd = ~cc.zf;
			C_GE:     cnd = ~lt;
			C_G:      cnd = ~lt & ~cc.zf;
			default:  cnd = 1'b0;
		endcase
	end

	assign res.result    = r;
	assign res.new_cc.zf = (r == '0);
	assign res.new_cc.sf = r[63];
	assign res.new_cc.of = ovf;
	assign res.cond      = cnd & ((icode == IC_JXX) | (icode == IC_RRMOVQ));

endmodule

>>> rtl/y86_execute_stage.sv
// Top level of the Y86-64 execute stage: input register, ALU and result register.
//
//  channel | handshake              | payload
//  --------+------------------------+-------------------------------------------------
//  in      | in_valid / in_ready    | stat icode ifun val_a val_b val_c dest_e dest_m
//          |                        | mem_stage_stat wb_stage_stat
//  out     | out_valid / out_ready  | out_stat out_icode cond_true alu_result out_val_a
//          |                        | out_dest_e out_dest_m bubble_next
//
// One item per cycle unless out_ready stalls; out_valid is the result register's valid.
// The condition-code register updates when an OPq leaves the input register and no later
// stage has an exception, so the next item sees the new flags in the following cycle.
// Reset clears both valid bits and sets the condition codes to zero-flag only.
// A stall on the output holds the result register and then the input register in turn.
module y86_execute_stage import y86_exe_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  stat,
	input  logic [3:0]  icode,
	input  logic [3:0]  ifun,
	input  logic [63:0] val_a,
	input  logic [63:0] val_b,
	input  logic [63:0] val_c,
	input  logic [3:0]  dest_e,
	input  logic [3:0]  dest_m,
	input  logic [1:0]  mem_stage_stat,
	input  logic [1:0]  wb_stage_stat,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  out_stat,
	output logic [3:0]  out_icode,
	output logic        cond_true,
	output logic [63:0] alu_result,
	output logic [63:0] out_val_a,
	output logic [3:0]  out_dest_e,
	output logic [3:0]  out_dest_m,
	output logic        bubble_next
);

	logic        valid_s1;
	logic [1:0]  stat_s1;
	logic [3:0]  icode_s1;
	logic [3:0]  ifun_s1;
	logic [63:0] val_a_s1;
	logic [63:0] val_b_s1;
	logic [63:0] val_c_s1;
	logic [3:0]  dest_e_s1;
	logic [3:0]  dest_m_s1;
	logic        except_s1;

	logic        valid_s2;
	cc_t         cc_q;
	alu_res_t    res;
	logic        s2_free;
	logic        adv_s1;

	assign s2_free  = ~valid_s2 | out_ready;
	assign adv_s1   = valid_s1 & s2_free;
	assign in_ready = ~valid_s1 | s2_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			stat_s1   <= stat;
			icode_s1  <= icode;
			ifun_s1   <= ifun;
			val_a_s1  <= val_a;
			val_b_s1  <= val_b;
			val_c_s1  <= val_c;
			dest_e_s1 <= dest_e;
			dest_m_s1 <= dest_m;
			except_s1 <= (mem_stage_stat != STAT_AOK) | (wb_stage_stat != STAT_AOK);
		end
	end

	y86_exe_alu u_alu (
		.icode (icode_s1),
		.ifun  (ifun_s1),
		.val_a (val_a_s1),
		.val_b (val_b_s1),
		.val_c (val_c_s1),
		.cc    (cc_q),
		.res   (res)
	);

	// Flags are committed only as the OPq transfers into the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cc_q <= CC_RESET;
		end else if (adv_s1 && icode_s1 == IC_OPQ && !except_s1) begin
			cc_q <= res.new_cc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			out_stat    <= stat_s1;
			out_icode   <= icode_s1;
			cond_true   <= res.cond;
			alu_result  <= res.result;
			out_val_a   <= val_a_s1;
			out_dest_e  <= (icode_s1 == IC_RRMOVQ && !res.cond) ? REG_NONE : dest_e_s1;
			out_dest_m  <= dest_m_s1;
			bubble_next <= except_s1;
		end
	end

	assign out_valid = valid_s2;

endmodule

>>> rtl/y86_exe_checker.sv
// Port-level checks for the Y86-64 execute stage, bound to the top level.
module y86_exe_checker import y86_exe_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [3:0] out_icode,
	input logic       cond_true,
	input logic [3:0] out_dest_e
);

	// A result that is not taken stays on the port unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_icode) && $stable(out_dest_e))
		else $error("result changed while stalled");

	// With the result register free or draining, the stage must take a new item.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid || out_ready |-> in_ready)
		else $error("input stalled while output side can move");

	// Only jumps and conditional moves carry a true condition.
	a_cond_icode: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && cond_true |-> out_icode == IC_JXX || out_icode == IC_RRMOVQ)
		else $error("condition true for non-branch instruction");

	// A conditional move that fails writes no register.
	a_cmov_fail: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_icode == IC_RRMOVQ && !cond_true |-> out_dest_e == REG_NONE)
		else $error("failed conditional move kept its destination");

endmodule

bind y86_execute_stage y86_exe_checker u_y86_exe_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.out_icode  (out_icode),
	.cond_true  (cond_true),
	.out_dest_e (out_dest_e)
);
